### design/lerr_pkg.sv
// types and constants shared by the ramp renderer modules
// no dependencies
package lerr_pkg;

    localparam int MAX_LEDS = 1024;

    localparam logic [16:0] FULL_SCALE = 17'd65536;
    localparam logic [16:0] HALF_SCALE = 17'd32768;

    // step counts of the shared add/subtract unit
    localparam logic [5:0] DIV_STEPS  = 6'd32;
    localparam logic [5:0] PROG_STEPS = 6'd17;
    localparam logic [5:0] CH_STEPS   = 6'd9;

    localparam logic [31:0] FADE_MULT = 32'd255;

    typedef enum logic [1:0] {
        REQ_RESET = 2'd0,
        REQ_START = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    localparam logic [1:0] EFF_STATIC = 2'd0;
    localparam logic [1:0] EFF_SABER  = 2'd1;
    localparam logic [1:0] EFF_FADE   = 2'd2;

    localparam logic [2:0] CFG_DURATION  = 3'd0;
    localparam logic [2:0] CFG_EFFECT    = 3'd1;
    localparam logic [2:0] CFG_START_LED = 3'd2;
    localparam logic [2:0] CFG_LED_COUNT = 3'd3;
    localparam logic [2:0] CFG_ON_COLOR  = 3'd4;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SABER,
        S_FSCALE,
        S_FCHAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [31:0] duration_ms;
        logic [1:0]  effect_kind;
        logic [9:0]  start_led;
        logic [10:0] led_count;
        logic [23:0] on_color;
    } t_cfg;

    typedef struct packed {
        logic        load;
        logic        div;
        logic [31:0] operand;
        logic [31:0] qinit;
        logic [5:0]  steps;
    } t_alu_cmd;

    typedef struct packed {
        logic        done;
        logic [32:0] acc;
        logic [31:0] quo;
    } t_alu_sts;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        updated;
        logic        running;
        logic [16:0] progress;
    } t_res;

endpackage

### design/lerr_alu.sv
// shared shift and add/subtract unit: restoring divide or msb-first multiply,
// one bit per cycle; depends on lerr_pkg
module lerr_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lerr_pkg::t_alu_cmd i_cmd,
    output lerr_pkg::t_alu_sts o_sts
);
    import lerr_pkg::*;

    logic [32:0] r_acc, n_acc;
    logic [31:0] r_q, n_q;
    logic [31:0] r_m;
    logic        r_div;
    logic [5:0]  r_cnt;

    logic [32:0] a_sh;
    logic [33:0] b_op;
    logic [33:0] sum;

    always_comb begin
        a_sh = {r_acc[31:0], r_div ? r_q[31] : 1'b0};
        if (r_div) begin
            b_op = ~{2'b00, r_m};
        end else if (r_q[31]) begin
            b_op = {2'b00, r_m};
        end else begin
            b_op = 34'd0;
        end
        sum = {1'b0, a_sh} + b_op + {33'd0, r_div};
        if (r_div) begin
            // trial subtract: keep the shifted remainder when it went negative
            n_acc = sum[33] ? a_sh : sum[32:0];
            n_q   = {r_q[30:0], ~sum[33]};
        end else begin
            n_acc = sum[32:0];
            n_q   = {r_q[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_cmd.load) begin
            r_cnt <= i_cmd.steps;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= 33'd0;
            r_q   <= i_cmd.qinit;
            r_m   <= i_cmd.operand;
            r_div <= i_cmd.div;
        end else if (r_cnt != 6'd0) begin
            r_acc <= n_acc;
            r_q   <= n_q;
        end
    end

    assign o_sts.done = (r_cnt == 6'd0);
    assign o_sts.acc  = r_acc;
    assign o_sts.quo  = r_q;

endmodule

### design/lerr_core.sv
// ramp state, request sequencer and result registers of the ramp renderer;
// depends on lerr_pkg and drives the shared unit lerr_alu
module lerr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lerr_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic               i_dir_on,
    input  logic               i_keep_direction,
    input  logic [15:0]        i_elapsed_ms,
    input  logic [9:0]         i_pixel_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lerr_pkg::t_res     o_res,
    output lerr_pkg::t_alu_cmd o_alu_cmd,
    input  lerr_pkg::t_alu_sts i_alu_sts
);
    import lerr_pkg::*;

    t_state      r_state, n_state;
    logic [16:0] r_progress, n_progress;
    logic        r_active, n_active;
    logic        r_dir, n_dir;
    logic [9:0]  r_pix, n_pix;
    logic [8:0]  r_scale, n_scale;
    logic [1:0]  r_ch, n_ch;
    t_res        r_res, n_res;
    t_res        r_out, n_out;
    logic        r_out_valid, n_out_valid;

    t_req        req;
    logic        accept;
    logic        dir_sel;
    logic [10:0] strip_n;
    logic [10:0] origin;
    logic [10:0] longer;
    logic [9:0]  gap;
    logic [10:0] saber_reach;
    logic [32:0] sum_up;
    logic [7:0]  fade_s;
    logic [8:0]  scale1;

    always_comb begin
        req     = t_req'(i_req_type);
        accept  = i_in_valid && (r_state == S_IDLE);
        dir_sel = i_keep_direction ? r_dir : i_dir_on;
        strip_n = (i_cfg.led_count > 11'(MAX_LEDS)) ? 11'(MAX_LEDS) : i_cfg.led_count;
        // a 10-bit origin is not limited to the strip and can pass its last pixel
        origin  = {1'b0, i_cfg.start_led};
        longer  = (origin > (strip_n >> 1)) ? origin + 11'd1 : strip_n - origin;
        gap     = (r_pix >= i_cfg.start_led) ? r_pix - i_cfg.start_led
                                             : i_cfg.start_led - r_pix;
        saber_reach = i_alu_sts.acc[26:16];
        sum_up  = {16'd0, r_progress} + {1'b0, i_alu_sts.quo};
        fade_s  = i_alu_sts.acc[23:16];
        scale1  = {1'b0, fade_s} + 9'd1;
    end

    always_comb begin
        n_state     = r_state;
        n_progress  = r_progress;
        n_active    = r_active;
        n_dir       = r_dir;
        n_pix       = r_pix;
        n_scale     = r_scale;
        n_ch        = r_ch;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_alu_cmd   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res.red      = 8'd0;
                    n_res.green    = 8'd0;
                    n_res.blue     = 8'd0;
                    n_res.updated  = 1'b0;
                    n_res.running  = r_active;
                    n_res.progress = r_progress;
                    n_pix          = i_pixel_index;
                    n_state        = S_FIN;
                    case (req)
                        REQ_RESET: begin
                            n_progress     = dir_sel ? 17'd0 : FULL_SCALE;
                            n_active       = 1'b0;
                            n_dir          = dir_sel;
                            n_res.running  = 1'b0;
                            n_res.progress = dir_sel ? 17'd0 : FULL_SCALE;
                        end
                        REQ_START: begin
                            n_active      = 1'b1;
                            n_dir         = i_dir_on;
                            n_res.running = 1'b1;
                        end
                        REQ_TICK: begin
                            if (r_active && i_elapsed_ms != 16'd0) begin
                                if (i_cfg.duration_ms == 32'd0) begin
                                    n_progress     = r_dir ? FULL_SCALE : 17'd0;
                                    n_active       = 1'b0;
                                    n_res.updated  = 1'b1;
                                    n_res.running  = 1'b0;
                                    n_res.progress = r_dir ? FULL_SCALE : 17'd0;
                                end else begin
                                    o_alu_cmd.load    = 1'b1;
                                    o_alu_cmd.div     = 1'b1;
                                    o_alu_cmd.operand = i_cfg.duration_ms;
                                    o_alu_cmd.qinit   = {i_elapsed_ms, 16'd0};
                                    o_alu_cmd.steps   = DIV_STEPS;
                                    n_state           = S_DIV;
                                end
                            end
                        end
                        default: begin
                            if ({1'b0, i_pixel_index} < strip_n) begin
                                case (i_cfg.effect_kind)
                                    EFF_STATIC: begin
                                        if (r_progress > HALF_SCALE) begin
                                            n_res.red   = i_cfg.on_color[23:16];
                                            n_res.green = i_cfg.on_color[15:8];
                                            n_res.blue  = i_cfg.on_color[7:0];
                                        end
                                    end
                                    EFF_SABER: begin
                                        o_alu_cmd.load    = 1'b1;
                                        o_alu_cmd.operand = {21'd0, longer};
                                        o_alu_cmd.qinit   = {r_progress, 15'd0};
                                        o_alu_cmd.steps   = PROG_STEPS;
                                        n_state           = S_SABER;
                                    end
                                    EFF_FADE: begin
                                        o_alu_cmd.load    = 1'b1;
                                        o_alu_cmd.operand = FADE_MULT;
                                        o_alu_cmd.qinit   = {r_progress, 15'd0};
                                        o_alu_cmd.steps   = PROG_STEPS;
                                        n_state           = S_FSCALE;
                                    end
                                    default: begin
                                        // unused effect code stays black
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (i_alu_sts.done) begin
                    n_res.updated = 1'b1;
                    if (r_dir) begin
                        if (sum_up >= {16'd0, FULL_SCALE}) begin
                            n_progress = FULL_SCALE;
                            n_active   = 1'b0;
                        end else begin
                            n_progress = sum_up[16:0];
                        end
                    end else if (i_alu_sts.quo >= {15'd0, r_progress}) begin
                        n_progress = 17'd0;
                        n_active   = 1'b0;
                    end else begin
                        n_progress = r_progress - i_alu_sts.quo[16:0];
                    end
                    n_res.running  = n_active;
                    n_res.progress = n_progress;
                    n_state        = S_FIN;
                end
            end
            S_SABER: begin
                if (i_alu_sts.done) begin
                    if ({1'b0, gap} < saber_reach) begin
                        n_res.red   = i_cfg.on_color[23:16];
                        n_res.green = i_cfg.on_color[15:8];
                        n_res.blue  = i_cfg.on_color[7:0];
                    end
                    n_state = S_FIN;
                end
            end
            S_FSCALE: begin
                if (i_alu_sts.done) begin
                    n_scale           = scale1;
                    n_ch              = CH_RED;
                    o_alu_cmd.load    = 1'b1;
                    o_alu_cmd.operand = {24'd0, i_cfg.on_color[23:16]};
                    o_alu_cmd.qinit   = {scale1, 23'd0};
                    o_alu_cmd.steps   = CH_STEPS;
                    n_state           = S_FCHAN;
                end
            end
            S_FCHAN: begin
                if (i_alu_sts.done) begin
                    case (r_ch)
                        CH_RED:   n_res.red   = i_alu_sts.acc[15:8];
                        CH_GREEN: n_res.green = i_alu_sts.acc[15:8];
                        default:  n_res.blue  = i_alu_sts.acc[15:8];
                    endcase
                    if (r_ch == CH_BLUE) begin
                        n_state = S_FIN;
                    end else begin
                        n_ch              = r_ch + 2'd1;
                        o_alu_cmd.load    = 1'b1;
                        o_alu_cmd.operand = (r_ch == CH_RED) ? {24'd0, i_cfg.on_color[15:8]}
                                                             : {24'd0, i_cfg.on_color[7:0]};
                        o_alu_cmd.qinit   = {r_scale, 23'd0};
                        o_alu_cmd.steps   = CH_STEPS;
                    end
                end
            end
            S_FIN: begin
                // finished item waits here until the result register frees up
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_progress  <= 17'd0;
            r_active    <= 1'b0;
            r_dir       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_progress  <= n_progress;
            r_active    <= n_active;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix   <= n_pix;
        r_scale <= n_scale;
        r_ch    <= n_ch;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### design/led_effect_ramp_renderer.sv
// top level of the led ramp renderer: configuration registers, sequencer and
// shared arithmetic unit; depends on lerr_pkg, lerr_alu and lerr_core
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    req_type, dir_on, keep_direction,
//                                                  elapsed_ms, pixel_index
//   out      output     o_out_valid / i_out_ready  red, green, blue, updated,
//                                                  is_running, progress_now
//   cfg      input      i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// reset, start, idle ticks, static and off-strip queries leave the arithmetic unit unused;
// ticks that step the ramp over a nonzero duration run the 32 one-bit divide steps,
// lightsaber queries 17 multiply steps and fade queries 17 + 3 x 9 multiply steps,
// all through the one shared add/subtract unit; one item is taken at a time
// reset is synchronous, active low, and restores ramp state and configuration registers
// a finished result waits in a staging register while the output stalls
module led_effect_ramp_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic        i_dir_on,
    input  logic        i_keep_direction,
    input  logic [15:0] i_elapsed_ms,
    input  logic [9:0]  i_pixel_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_updated,
    output logic        o_is_running,
    output logic [16:0] o_progress_now
);
    import lerr_pkg::*;

    t_cfg     r_cfg, n_cfg;
    t_alu_cmd alu_cmd;
    t_alu_sts alu_sts;
    t_res     res;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DURATION:  n_cfg.duration_ms = i_cfg_data;
                CFG_EFFECT:    n_cfg.effect_kind = i_cfg_data[1:0];
                CFG_START_LED: n_cfg.start_led   = i_cfg_data[9:0];
                CFG_LED_COUNT: n_cfg.led_count   = i_cfg_data[10:0];
                CFG_ON_COLOR:  n_cfg.on_color    = i_cfg_data[23:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duration_ms <= 32'd3000;
            r_cfg.effect_kind <= EFF_STATIC;
            r_cfg.start_led   <= 10'd0;
            r_cfg.led_count   <= 11'd1024;
            r_cfg.on_color    <= 24'hFFFFFF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;

    lerr_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (alu_cmd),
        .o_sts   (alu_sts)
    );

    lerr_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_dir_on         (i_dir_on),
        .i_keep_direction (i_keep_direction),
        .i_elapsed_ms     (i_elapsed_ms),
        .i_pixel_index    (i_pixel_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_res            (res),
        .o_alu_cmd        (alu_cmd),
        .i_alu_sts        (alu_sts)
    );

    assign o_red          = res.red;
    assign o_green        = res.green;
    assign o_blue         = res.blue;
    assign o_updated      = res.updated;
    assign o_is_running   = res.running;
    assign o_progress_now = res.progress;

endmodule

### design/lerr_checker.sv
// port-level checks for the led ramp renderer, bound to the top level;
// depends only on the top level's ports
module lerr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [31:0] i_cfg_data,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_req_type,
    input logic        i_dir_on,
    input logic        i_keep_direction,
    input logic [15:0] i_elapsed_ms,
    input logic [9:0]  i_pixel_index,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic        o_updated,
    input logic        o_is_running,
    input logic [16:0] o_progress_now
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // one item at a time: ready drops right after an item is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

    a_prog_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_progress_now <= 17'd65536)
        else $error("progress above full scale");

    // only ticks raise the updated flag, and ticks render no color
    a_upd_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_updated |-> (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("color on an updating tick");

endmodule

bind led_effect_ramp_renderer lerr_checker u_lerr_checker (.*);
